FILE: rtl/core/ida_pkg.sv
package ida_pkg;

   // request and response field widths
   localparam int OPCODE_W      = 2;
   localparam int GIVEN_ID_W    = 6;
   localparam int HANDLE_DATA_W = 32;
   localparam int STATUS_W      = 2;
   localparam int IN_USE_W      = 7;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BAD_ID = 2'd2
   } status_type;

   // write command for the slot-in-use bits
   typedef struct packed {
      logic wr_en;
      logic set;
   } valid_cmd_type;

endpackage

FILE: rtl/core/ida_fwd_ram.sv
// Single-port-write RAM with registered read; the most recent write is
// forwarded over a read that was issued on the same edge.
module ida_fwd_ram
   import ida_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic             fwd_ok_ff;
   logic [AW-1:0]    fwd_addr_ff;
   logic [WIDTH-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ok_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_ok_ff <= 1'b1;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // last write is never older than the read, or already in the array
   assign rd_data = (fwd_ok_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : rd_data_ff;

endmodule

FILE: rtl/core/ida_valid_bits.sv
// Slot-in-use bits held in a 1-bit RAM, cleared by a sweep after reset.
module ida_valid_bits
   import ida_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     ready,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic                     rd_bit,
   input  valid_cmd_type            cmd,
   input  logic [$clog2(DEPTH)-1:0] wr_addr
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic          bits_ff [DEPTH];
   logic          clr_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          rd_bit_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          fwd_ok_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic          fwd_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         bits_ff[clr_addr_ff] <= 1'b0;
      end else if (cmd.wr_en) begin
         bits_ff[wr_addr] <= cmd.set;
      end
      if (rd_en) begin
         rd_bit_ff  <= bits_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ok_ff <= 1'b0;
      end else if (!clr_ff && cmd.wr_en) begin
         fwd_ok_ff <= 1'b1;
      end
      if (cmd.wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_bit_ff  <= cmd.set;
      end
   end

   assign ready  = !clr_ff;
   assign rd_bit = (fwd_ok_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_bit_ff : rd_bit_ff;

endmodule

FILE: rtl/core/id_allocator_handle_table.sv
// Timing: the RAMs are read at the accepting edge; the execute stage then loads the
//   response register, raising rsp_tvalid, once no earlier response waits on rsp_tready.
// Throughput: one request per cycle while responses are taken; the execute stage writes
//   back the slot RAM, in-use bits and free stack while the next request reads them,
//   with forwarding. Reset: synchronous; counters and handshakes clear at once, then a
//   sweep of all CAPACITY slots clears the in-use bits; req_tready is low until it ends.
module id_allocator_handle_table
   import ida_pkg::*;
#(
   parameter int CAPACITY     = 64,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: opcode[1:0], given_id[7:2], handle_data[39:8]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response: status[1:0], granted_id[7:2], read_data[39:8], in_use_count[46:40], pad[47]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ID_W  = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // request fields
   opcode_type               req_opcode;
   logic [GIVEN_ID_W-1:0]    req_given_id;
   logic [HANDLE_DATA_W-1:0] req_handle_data;

   assign req_opcode      = opcode_type'(req_tdata[OPCODE_W-1:0]);
   assign req_given_id    = req_tdata[OPCODE_W +: GIVEN_ID_W];
   assign req_handle_data = req_tdata[OPCODE_W+GIVEN_ID_W +: HANDLE_DATA_W];

   // execute-stage request register
   logic                    busy_ff;
   opcode_type              op_ff;
   logic [GIVEN_ID_W-1:0]   id_ff;
   logic [HANDLE_WIDTH-1:0] data_ff;

   // allocator state
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CNT_W-1:0] used_ff, used_in;

   // response register
   logic                     rsp_valid_ff;
   status_type               status_ff, status_in;
   logic [GIVEN_ID_W-1:0]    granted_ff, granted_in;
   logic [HANDLE_DATA_W-1:0] rdata_ff, rdata_in;
   logic [IN_USE_W-1:0]      count_ff;

   logic accept;
   logic exec_fire;
   logic clr_done;

   // RAM interfaces
   logic                    slot_vld;
   logic [HANDLE_WIDTH-1:0] slot_handle;
   logic [ID_W-1:0]         stack_top;
   valid_cmd_type           vld_cmd;
   logic [ID_W-1:0]         slot_wr_addr;
   logic                    handle_wr;
   logic                    push;
   logic [ID_W-1:0]         stack_rd_addr;

   // decoded execute-stage values
   logic            in_range;
   logic [ID_W-1:0] id_addr;
   logic            have_stack;
   logic            have_fresh;
   logic [ID_W-1:0] pick;

   // the next request may enter as the current one executes
   assign exec_fire  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = clr_done && (!busy_ff || exec_fire);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (exec_fire) begin
         busy_ff <= 1'b0;
      end
      if (accept) begin
         op_ff   <= req_opcode;
         id_ff   <= req_given_id;
         data_ff <= HANDLE_WIDTH'(req_handle_data);
      end
   end

   assign in_range   = 32'(id_ff) < 32'(CAPACITY);
   assign id_addr    = ID_W'(id_ff);
   assign have_stack = (depth_ff != '0) && (depth_ff <= CAP_CNT);
   assign have_fresh = fresh_ff < CAP_CNT;
   assign pick       = have_stack ? stack_top : ID_W'(fresh_ff);

   always_comb begin
      status_in    = ST_OK;
      granted_in   = '0;
      rdata_in     = '0;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      used_in      = used_ff;
      vld_cmd      = '{wr_en: 1'b0, set: 1'b0};
      slot_wr_addr = id_addr;
      handle_wr    = 1'b0;
      push         = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            slot_wr_addr = pick;
            if (have_stack || have_fresh) begin
               if (have_stack) begin
                  depth_in = depth_ff - 1'b1;
               end else begin
                  fresh_in = fresh_ff + 1'b1;
               end
               vld_cmd    = '{wr_en: exec_fire, set: 1'b1};
               handle_wr  = exec_fire;
               used_in    = used_ff + 1'b1;
               granted_in = GIVEN_ID_W'(pick);
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_FREE: begin
            if (!in_range || !slot_vld) begin
               status_in = ST_BAD_ID;
            end else begin
               // freeing the topmost id retires it instead of stacking it
               if ((fresh_ff != '0) && (CNT_W'(id_addr) == fresh_ff - 1'b1)) begin
                  fresh_in = fresh_ff - 1'b1;
               end else if (depth_ff < CAP_CNT) begin
                  push     = exec_fire;
                  depth_in = depth_ff + 1'b1;
               end
               vld_cmd = '{wr_en: exec_fire, set: 1'b0};
               if (used_ff != '0) begin
                  used_in = used_ff - 1'b1;
               end
            end
         end
         OP_READ: begin
            if (!in_range) begin
               status_in = ST_BAD_ID;
            end else if (slot_vld) begin
               rdata_in = HANDLE_DATA_W'(slot_handle);
            end
         end
         default: begin
         end
      endcase
      if (!exec_fire) begin
         depth_in = depth_ff;
         fresh_in = fresh_ff;
         used_in  = used_ff;
      end
   end

   // the stack is read at the top it will have once the current request is done
   assign stack_rd_addr = ID_W'(depth_in - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fresh_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
         used_ff  <= used_in;
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (exec_fire) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         rdata_ff   <= rdata_in;
         count_ff   <= IN_USE_W'(used_in);
      end
   end

   ida_valid_bits #(
      .DEPTH (CAPACITY)
   ) u_valid (
      .clock   (clock),
      .reset   (reset),
      .ready   (clr_done),
      .rd_en   (accept),
      .rd_addr (ID_W'(req_given_id)),
      .rd_bit  (slot_vld),
      .cmd     (vld_cmd),
      .wr_addr (slot_wr_addr)
   );

   // handle words; a slot is only ever read through its in-use bit
   ida_fwd_ram #(
      .WIDTH (HANDLE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_handles (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ID_W'(req_given_id)),
      .rd_data (slot_handle),
      .wr_en   (handle_wr),
      .wr_addr (slot_wr_addr),
      .wr_data (data_ff)
   );

   // LIFO of freed ids
   ida_fwd_ram #(
      .WIDTH (ID_W),
      .DEPTH (CAPACITY)
   ) u_free_stack (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_top),
      .wr_en   (push),
      .wr_addr (ID_W'(depth_ff)),
      .wr_data (id_addr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, count_ff, rdata_ff, granted_ff, status_ff};

endmodule

FILE: test/tb_id_allocator_handle_table.sv
module tb_id_allocator_handle_table;
   import ida_pkg::*;

   localparam int SLOTS       = 64;
   localparam int PHASES      = 10;
   localparam int PHASE_LEN   = 95;
   localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch, in cycles
   localparam int STALL_LIMIT = 3000;  // cycles without any handshake before giving up
   localparam int TAIL_CYCLES = 8;     // idle tail after the two-stage pipeline has drained, in cycles

   typedef struct packed {
      opcode_type  op;
      logic [5:0]  id;
      logic [31:0] data;
   } table_req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  granted;
      logic [31:0] read_data;
      logic [6:0]  in_use;
   } table_rsp_type;

   // fixed = 1: the response is typed in below; otherwise the predictor supplies it
   typedef struct packed {
      table_req_type rq;
      logic          fixed;
      table_rsp_type rs;
   } dir_row_type;

   localparam table_rsp_type NO_RSP = '{ST_OK, 6'd0, 32'h0, 7'd0};

   localparam dir_row_type DIRECTED [24] = '{
      // empty table straight out of reset
      '{'{OP_READ,  6'd0,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd0}},
      '{'{OP_READ,  6'd63, 32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd0}},
      // freeing ids that were never handed out
      '{'{OP_FREE,  6'd0,  32'h0000_0000}, 1'b1, '{ST_BAD_ID, 6'd0, 32'h0000_0000, 7'd0}},
      '{'{OP_FREE,  6'd63, 32'hFFFF_FFFF}, 1'b1, '{ST_BAD_ID, 6'd0, 32'h0000_0000, 7'd0}},
      // unused opcode does nothing
      '{'{OP_NONE,  6'd63, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd0}},
      // fresh ids come out in order
      '{'{OP_ALLOC, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd1}},
      '{'{OP_ALLOC, 6'd0,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd1, 32'h0000_0000, 7'd2}},
      '{'{OP_ALLOC, 6'd21, 32'hA5A5_A5A5}, 1'b1, '{ST_OK,     6'd2, 32'h0000_0000, 7'd3}},
      '{'{OP_READ,  6'd0,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'hFFFF_FFFF, 7'd3}},
      '{'{OP_READ,  6'd1,  32'hFFFF_FFFF}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd3}},
      '{'{OP_READ,  6'd2,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'hA5A5_A5A5, 7'd3}},
      // free below the top goes to the stack; then the slot reads as unused
      '{'{OP_FREE,  6'd1,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd2}},
      '{'{OP_READ,  6'd1,  32'h0000_0000}, 1'b1, '{ST_OK,     6'd0, 32'h0000_0000, 7'd2}},
      '{'{OP_FREE,  6'd1,  32'h0000_0000}, 1'b1, '{ST_BAD_ID, 6'd0, 32'h0000_0000, 7'd2}},
      // reuse from the stack, retire from the top, LIFO order
      '{'{OP_ALLOC, 6'd0,  32'h1234_5678}, 1'b0, NO_RSP},
      '{'{OP_FREE,  6'd2,  32'h0000_0000}, 1'b0, NO_RSP},
      '{'{OP_ALLOC, 6'd0,  32'h5A5A_5A5A}, 1'b0, NO_RSP},
      '{'{OP_READ,  6'd2,  32'h0000_0000}, 1'b0, NO_RSP},
      '{'{OP_FREE,  6'd0,  32'h0000_0000}, 1'b0, NO_RSP},
      '{'{OP_FREE,  6'd1,  32'h0000_0000}, 1'b0, NO_RSP},
      '{'{OP_ALLOC, 6'd0,  32'h0000_FFFF}, 1'b0, NO_RSP},
      '{'{OP_ALLOC, 6'd0,  32'hFFFF_0000}, 1'b0, NO_RSP},
      '{'{OP_ALLOC, 6'd42, 32'h8000_0001}, 1'b0, NO_RSP},
      '{'{OP_NONE,  6'd0,  32'h0000_0000}, 1'b0, NO_RSP}
   };

   // share of allocations per random phase; the first one fills the table past full
   localparam int ALLOC_PCT [PHASES] = '{100, 30, 60, 90, 10, 50, 95, 20, 70, 40};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // opcode[1:0], given_id[7:2], handle_data[39:8]
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // status[1:0], granted_id[7:2], read_data[39:8], in_use_count[46:40], pad[47]
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // shadow of the handle table
   logic [31:0] slot_word [SLOTS];
   bit          slot_live [SLOTS];
   logic [5:0]  freed_ids [SLOTS];
   int unsigned freed_depth;
   int unsigned fresh_mark;
   int unsigned live_total;

   table_rsp_type awaited_results [$];

   // traffic control shared between the sender, the receiver and the sequencer
   bit tx_quiet;
   bit rx_quiet;
   bit hold_rsp_req;

   int err_count;
   int mismatch_count;
   int idle_cycles;
   int n_alloc, n_full, n_free, n_bad_free, n_read, n_other, peak_live, n_long_holds, n_drains;

   always #5 clock = ~clock;

   id_allocator_handle_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Applies one request to the shadow table and returns the response it must give.
   function automatic table_rsp_type handle_table_step(table_req_type rq);
      table_rsp_type rs;
      logic [5:0]    pick;
      bit            have;
      rs = NO_RSP;
      case (rq.op)
         OP_ALLOC: begin
            n_alloc++;
            have = 1'b1;
            if (freed_depth > 0) begin
               freed_depth--;
               pick = freed_ids[freed_depth];
            end else if (fresh_mark < SLOTS) begin
               pick = fresh_mark[5:0];
               fresh_mark++;
            end else begin
               have = 1'b0;
               pick = '0;
            end
            if (have) begin
               slot_word[pick] = rq.data;
               slot_live[pick] = 1'b1;
               live_total++;
               rs.granted = pick;
            end else begin
               rs.status = ST_FULL;
               n_full++;
            end
         end
         OP_FREE: begin
            n_free++;
            if (!slot_live[rq.id]) begin
               rs.status = ST_BAD_ID;
               n_bad_free++;
            end else begin
               // topmost id retires the fresh mark, anything else is stacked
               if (fresh_mark > 0 && rq.id == fresh_mark - 1)
                  fresh_mark--;
               else begin
                  freed_ids[freed_depth] = rq.id;
                  freed_depth++;
               end
               slot_word[rq.id] = '0;
               slot_live[rq.id] = 1'b0;
               live_total--;
            end
         end
         OP_READ: begin
            n_read++;
            if (slot_live[rq.id])
               rs.read_data = slot_word[rq.id];
         end
         default: n_other++;
      endcase
      rs.in_use = live_total[6:0];
      if (live_total > peak_live)
         peak_live = live_total;
      return rs;
   endfunction

   // Random request; frees and reads mostly aim at live ids so that they do real work.
   function automatic table_req_type random_request(int alloc_pct);
      table_req_type rq;
      int            sel;
      int            start;
      bit            found;
      rq.id = 6'($urandom_range(0, SLOTS - 1));
      case ($urandom_range(0, 7))
         0:       rq.data = '1;
         1:       rq.data = '0;
         default: rq.data = $urandom;
      endcase
      if ($urandom_range(1, 100) <= alloc_pct)
         rq.op = OP_ALLOC;
      else begin
         sel = $urandom_range(0, 19);
         rq.op = (sel == 0) ? OP_NONE : (sel <= 11) ? OP_FREE : OP_READ;
         if ($urandom_range(0, 3) != 0) begin
            start = rq.id;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && slot_live[(start + i) % SLOTS]) begin
                  rq.id = 6'((start + i) % SLOTS);
                  found = 1'b1;
               end
            end
         end
      end
      return rq;
   endfunction

   // Offers one request after a random gap; returns at the edge that accepts it.
   // valid is left high so a back-to-back request never lowers and raises it in one step.
   task automatic send_request(input table_req_type rq, input bit fixed,
                               input table_rsp_type fixed_rsp);
      int            gap;
      table_rsp_type predicted;
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.data, rq.id, rq.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = handle_table_step(rq);
      awaited_results.push_back(fixed ? fixed_rsp : predicted);
   endtask

   task automatic wait_all_results();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_response(input logic [RSP_TDATA_W-1:0] d);
      table_rsp_type got;
      table_rsp_type want;
      got.status    = status_type'(d[1:0]);
      got.granted   = d[7:2];
      got.read_data = d[39:8];
      got.in_use    = d[46:40];
      if (awaited_results.size() == 0) begin
         err_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: unexpected response: status %0d id %0d data %h count %0d",
                     got.status, got.granted, got.read_data, got.in_use);
      end else begin
         want = awaited_results.pop_front();
         if (got !== want) begin
            err_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: status %0d/%0d id %0d/%0d data %h/%h count %0d/%0d (exp/act)",
                        want.status, got.status, want.granted, got.granted,
                        want.read_data, got.read_data, want.in_use, got.in_use);
         end
      end
   endtask

   // Receiver: random stall before each response, or one long hold when asked.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            stall = LONG_HOLD;
            hold_rsp_req = 1'b0;
            n_long_holds++;
         end else
            stall = rx_quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_response(rsp_tdata);
      end
   end

   // Watchdog: any handshake restarts the count; the reset sweep is well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     idle_cycles, awaited_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      table_req_type rq;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      tx_quiet     = 1'b0;
      rx_quiet     = 1'b0;
      hold_rsp_req = 1'b0;
      idle_cycles  = 0;
      freed_depth  = 0;
      fresh_mark   = 0;
      live_total   = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_word[i] = '0;
         slot_live[i] = 1'b0;
         freed_ids[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part: extremes, every opcode, bad frees, stack reuse and top retirement
      foreach (DIRECTED[i])
         send_request(DIRECTED[i].rq, DIRECTED[i].fixed, DIRECTED[i].rs);

      // random phases with varying allocation pressure and idling
      for (int ph = 0; ph < PHASES; ph++) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         // long receiver hold with the sender flat out: the pipeline fills and stalls
         if (ph == 2 || ph == 6) begin
            tx_quiet     = 1'b1;
            rx_quiet     = 1'b0;
            hold_rsp_req = 1'b1;
         end
         for (int k = 0; k < PHASE_LEN; k++) begin
            rq = random_request(ALLOC_PCT[ph]);
            send_request(rq, 1'b0, NO_RSP);
         end
         // sender pauses until everything in flight has come back
         if (ph % 3 == 2) begin
            req_tvalid <= 1'b0;
            wait_all_results();
            n_drains++;
         end
      end

      req_tvalid <= 1'b0;
      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d allocations (%0d refused as full), %0d frees (%0d rejected),",
               n_alloc, n_full, n_free, n_bad_free);
      $display("  %0d reads, %0d unused opcodes; peak ids in use %0d of %0d;",
               n_read, n_other, peak_live, SLOTS);
      $display("  %0d long response holds, %0d full drains, %0d mismatches",
               n_long_holds, n_drains, mismatch_count);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ida_pkg.sv
rtl/core/ida_fwd_ram.sv
rtl/core/ida_valid_bits.sv
rtl/core/id_allocator_handle_table.sv
test/tb_id_allocator_handle_table.sv
